// ===== rtl/core/srrw_pkg.sv =====
// Shared types, constants and helpers for the selective-repeat receive window.
`timescale 1ns / 1ps
`default_nettype none

package srrw_pkg;

  localparam int WINDOW_SLOTS = 64;
  localparam int SLOT_W       = $clog2(WINDOW_SLOTS);
  localparam int SIZE_W       = $clog2(WINDOW_SLOTS + 1);

  // shared divider widths
  localparam int DVD_W = 31;
  localparam int DVS_W = 16;
  localparam int CNT_W = $clog2(DVD_W);

  localparam int OFS_W = 31;
  localparam int LEN_W = 16;
  localparam int REQ_W = 32;

  typedef enum logic [1:0] {
    OP_SEG = 2'd0,
    OP_ADV = 2'd1,
    OP_REQ = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    RC_IGNORED  = 3'd0,
    RC_HEAD     = 3'd1,
    RC_AHEAD    = 3'd2,
    RC_DUP      = 3'd3,
    RC_ADVANCED = 3'd4,
    RC_REQUEST  = 3'd5,
    RC_NONE     = 3'd6
  } rcode_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

  // window size limited to 1..WINDOW_SLOTS
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [15:0] v);
    logic [SIZE_W-1:0] r;
    if (v == 16'd0) begin
      r = SIZE_W'(1);
    end else if (v > 16'(WINDOW_SLOTS)) begin
      r = SIZE_W'(WINDOW_SLOTS);
    end else begin
      r = v[SIZE_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/srrw_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by all operations.
`timescale 1ns / 1ps
`default_nettype none

module srrw_div
  import srrw_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;

  logic [DVS_W:0]   trial;
  logic             qbit;
  logic [DVS_W-1:0] rem_nxt;

  always_comb begin
    trial = {rem_r, dvd_r[DVD_W-1]};
    qbit  = (trial >= {1'b0, dvs_r});
    if (qbit) begin
      rem_nxt = DVS_W'(trial - {1'b0, dvs_r});
    end else begin
      rem_nxt = trial[DVS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    done_r <= 1'b0;
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(DVD_W - 1);
      dvd_r  <= req.dividend;
      dvs_r  <= req.divisor;
      rem_r  <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], qbit};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = dvd_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

// ===== rtl/core/selective_repeat_receive_window_top.sv =====
// Top level of the selective-repeat receive window: sequencer, slot marks, result register.
`timescale 1ns / 1ps
`default_nettype none

// Receive side of a selective-repeat window. A ring of 64 received marks (flip-flops,
// cleared at reset, no clearing pass), a head slot and an active window size are kept.
// op 0 files a parsed segment header at the head slot or a slot ahead of it, op 1 walks
// the head over received slots, op 2 sets the window size and lists missing slots, one
// result word per missing slot with the final one flagged by out_last. All arithmetic
// that needs a modulo or a quotient goes through one shared restoring divider that
// yields one bit per cycle. Steps per input word: op 0 rejected at the header goes
// straight to its result; op 0 otherwise takes the head modulo, then the distance
// quotient unless it fills the head slot or has zero length; op 1 walks the head slot
// by slot and uses the divider only when the head sits beyond a shrunk window; op 2
// takes the head modulo and then scans every active slot. in_ready is high only while
// the sequencer is idle; the output register lets a new word in while the last result
// still waits.
// cfg_wdata is clamped to 1..64 and loads the active size at once.
module selective_repeat_receive_window_top
  import srrw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,

  input  wire logic              cfg_we,
  input  wire logic [SIZE_W-1:0] cfg_wdata,

  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_op,
  input  wire logic [OFS_W-1:0]  in_window_start,
  input  wire logic [LEN_W-1:0]  in_expected_len,
  input  wire logic              in_seg_ok,
  input  wire logic              in_seg_from_peer,
  input  wire logic [OFS_W-1:0]  in_seg_start,
  input  wire logic [LEN_W-1:0]  in_seg_len,
  input  wire logic [15:0]       in_window_bound,

  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [2:0]             out_result_code,
  output logic                   out_store_packet,
  output logic [SIZE_W-1:0]      out_frames_moved,
  output logic [REQ_W-1:0]       out_req_start,
  output logic [LEN_W-1:0]       out_req_length,
  output logic                   out_last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HMOD,   // head modulo active size
    S_SEG,    // head-slot check for a segment
    S_DIV,    // segment distance quotient
    S_ADV,    // walk the head
    S_AMOD,   // wrap an out-of-range head
    S_REQ,    // scan for missing slots
    S_EMIT    // final result of the word
  } st_t;

  st_t                state_r;
  logic [WINDOW_SLOTS-1:0] rec_r;
  logic [SLOT_W-1:0]  head_r;
  logic [SIZE_W-1:0]  active_r;

  // latched input word
  logic [1:0]         op_r;
  logic [OFS_W-1:0]   wstart_r;
  logic [OFS_W-1:0]   sstart_r;
  logic [LEN_W-1:0]   elen_r;

  // working registers
  logic [SLOT_W-1:0]  hs_r;
  logic [SLOT_W-1:0]  h_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [SIZE_W-1:0]  moved_r;
  logic [SIZE_W-1:0]  i_r;
  logic [REQ_W-1:0]   rs_r;
  logic               have_r;

  // pending result
  logic [2:0]         res_code_r;
  logic               res_store_r;
  logic [SIZE_W-1:0]  res_moved_r;
  logic [REQ_W-1:0]   res_rs_r;
  logic [LEN_W-1:0]   res_rl_r;

  // output register
  logic               out_valid_r;
  logic [2:0]         out_code_r;
  logic               out_store_r;
  logic [SIZE_W-1:0]  out_moved_r;
  logic [REQ_W-1:0]   out_rs_r;
  logic [LEN_W-1:0]   out_rl_r;
  logic               out_last_r;

  // divider request
  logic               div_start_r;
  logic [DVD_W-1:0]   div_dvd_r;
  logic [DVS_W-1:0]   div_dvs_r;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic               out_free;
  logic               seg_reject;
  logic [SIZE_W-1:0]  bound_size;
  logic [SIZE_W-1:0]  seg_sum;
  logic [SLOT_W-1:0]  seg_slot;
  logic               dist_far;
  logic [SIZE_W-1:0]  h_inc;
  logic [SLOT_W-1:0]  h_wrap;
  logic [SIZE_W-1:0]  slot_inc;
  logic [SLOT_W-1:0]  slot_wrap;

  assign div_req.start    = div_start_r;
  assign div_req.dividend = div_dvd_r;
  assign div_req.divisor  = div_dvs_r;

  srrw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    out_free   = !out_valid_r || out_ready;
    seg_reject = !in_seg_ok || !in_seg_from_peer || (in_seg_start < in_window_start) ||
                 (in_seg_len != in_expected_len);
    bound_size = clamp_size(in_window_bound);

    // distance is below the active size whenever the slot is used
    dist_far = (div_rsp.quot >= DVD_W'(active_r));
    seg_sum  = SIZE_W'({1'b0, hs_r}) + div_rsp.quot[SIZE_W-1:0];
    if (seg_sum >= active_r) begin
      seg_slot = SLOT_W'(seg_sum - active_r);
    end else begin
      seg_slot = seg_sum[SLOT_W-1:0];
    end

    h_inc  = SIZE_W'({1'b0, h_r}) + SIZE_W'(1);
    h_wrap = (h_inc == active_r) ? '0 : h_inc[SLOT_W-1:0];

    slot_inc  = SIZE_W'({1'b0, slot_r}) + SIZE_W'(1);
    slot_wrap = (slot_inc == active_r) ? '0 : slot_inc[SLOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    div_start_r <= 1'b0;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rec_r       <= '0;
      head_r      <= '0;
      active_r    <= SIZE_W'(WINDOW_SLOTS);
      out_valid_r <= 1'b0;
      have_r      <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        active_r <= clamp_size(16'(cfg_wdata));
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r        <= in_op;
            wstart_r    <= in_window_start;
            sstart_r    <= in_seg_start;
            elen_r      <= in_expected_len;
            res_code_r  <= RC_IGNORED;
            res_store_r <= 1'b0;
            res_moved_r <= '0;
            res_rs_r    <= '0;
            res_rl_r    <= '0;
            unique case (in_op)
              OP_SEG: begin
                if (seg_reject) begin
                  state_r <= S_EMIT;
                end else begin
                  div_start_r <= 1'b1;
                  div_dvd_r   <= DVD_W'(head_r);
                  div_dvs_r   <= DVS_W'(active_r);
                  state_r     <= S_HMOD;
                end
              end
              OP_ADV: begin
                h_r     <= head_r;
                moved_r <= '0;
                state_r <= S_ADV;
              end
              OP_REQ: begin
                active_r    <= bound_size;
                div_start_r <= 1'b1;
                div_dvd_r   <= DVD_W'(head_r);
                div_dvs_r   <= DVS_W'(bound_size);
                state_r     <= S_HMOD;
              end
              default: begin
                state_r <= S_EMIT;
              end
            endcase
          end
        end

        S_HMOD: begin
          if (div_rsp.done) begin
            hs_r <= div_rsp.rem[SLOT_W-1:0];
            if (op_r == OP_REQ) begin
              slot_r  <= div_rsp.rem[SLOT_W-1:0];
              i_r     <= '0;
              rs_r    <= REQ_W'(wstart_r);
              have_r  <= 1'b0;
              state_r <= S_REQ;
            end else begin
              state_r <= S_SEG;
            end
          end
        end

        S_SEG: begin
          priority if (sstart_r == wstart_r && !rec_r[hs_r]) begin
            rec_r[hs_r] <= 1'b1;
            res_code_r  <= RC_HEAD;
            res_store_r <= 1'b1;
            state_r     <= S_EMIT;
          end else if (elen_r == '0) begin
            res_code_r <= RC_DUP;
            state_r    <= S_EMIT;
          end else begin
            div_start_r <= 1'b1;
            div_dvd_r   <= sstart_r - wstart_r;
            div_dvs_r   <= elen_r;
            state_r     <= S_DIV;
          end
        end

        S_DIV: begin
          if (div_rsp.done) begin
            priority if (dist_far || rec_r[seg_slot]) begin
              res_code_r <= RC_DUP;
            end else begin
              rec_r[seg_slot] <= 1'b1;
              res_code_r      <= RC_AHEAD;
              res_store_r     <= 1'b1;
            end
            state_r <= S_EMIT;
          end
        end

        S_ADV: begin
          if (moved_r < active_r && rec_r[h_r]) begin
            rec_r[h_r] <= 1'b0;
            moved_r    <= moved_r + SIZE_W'(1);
            if (SIZE_W'({1'b0, h_r}) >= active_r) begin
              // head left over from a shrink: needs a true modulo
              div_start_r <= 1'b1;
              div_dvd_r   <= DVD_W'(h_inc);
              div_dvs_r   <= DVS_W'(active_r);
              state_r     <= S_AMOD;
            end else begin
              h_r <= h_wrap;
            end
          end else begin
            head_r      <= h_r;
            res_code_r  <= RC_ADVANCED;
            res_moved_r <= moved_r;
            state_r     <= S_EMIT;
          end
        end

        S_AMOD: begin
          if (div_rsp.done) begin
            h_r     <= div_rsp.rem[SLOT_W-1:0];
            state_r <= S_ADV;
          end
        end

        S_REQ: begin
          // one request is held back so the final one can carry last
          if (i_r < active_r) begin
            if (!(rec_r[slot_r] == 1'b0 && have_r && !out_free)) begin
              if (!rec_r[slot_r]) begin
                if (have_r) begin
                  out_valid_r <= 1'b1;
                  out_code_r  <= res_code_r;
                  out_store_r <= 1'b0;
                  out_moved_r <= '0;
                  out_rs_r    <= res_rs_r;
                  out_rl_r    <= res_rl_r;
                  out_last_r  <= 1'b0;
                end
                res_code_r <= RC_REQUEST;
                res_rs_r   <= rs_r;
                res_rl_r   <= elen_r;
                have_r     <= 1'b1;
              end
              i_r    <= i_r + SIZE_W'(1);
              rs_r   <= rs_r + REQ_W'(elen_r);
              slot_r <= slot_wrap;
            end
          end else begin
            if (!have_r) begin
              res_code_r <= RC_NONE;
            end
            state_r <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_code_r  <= res_code_r;
            out_store_r <= res_store_r;
            out_moved_r <= res_moved_r;
            out_rs_r    <= res_rs_r;
            out_rl_r    <= res_rl_r;
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_code  = out_code_r;
  assign out_store_packet = out_store_r;
  assign out_frames_moved = out_moved_r;
  assign out_req_start    = out_rs_r;
  assign out_req_length   = out_rl_r;
  assign out_last         = out_last_r;

endmodule

`default_nettype wire

// ===== rtl/core/srrw_checker.sv =====
// Port-level assertions for the receive window, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module srrw_checker
  import srrw_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [2:0]        out_result_code,
  input wire logic              out_store_packet,
  input wire logic [SIZE_W-1:0] out_frames_moved,
  input wire logic [REQ_W-1:0]  out_req_start,
  input wire logic [LEN_W-1:0]  out_req_length,
  input wire logic              out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_code) &&
      $stable(out_req_start) && $stable(out_last))
    else $error("result word changed while stalled");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result_code <= RC_NONE)
    else $error("undefined result code");

  a_only_req_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_code != RC_REQUEST |-> out_last)
    else $error("non-request word without last");

  a_store_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_store_packet |->
      (out_result_code == RC_HEAD || out_result_code == RC_AHEAD))
    else $error("store flag on a word that stores nothing");

  a_fields_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_code != RC_REQUEST |->
      out_req_length == '0 && out_req_start == '0 &&
      (out_result_code == RC_ADVANCED || out_frames_moved == '0))
    else $error("stray field on a result word");

endmodule

bind selective_repeat_receive_window_top srrw_checker u_srrw_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_result_code  (out_result_code),
  .out_store_packet (out_store_packet),
  .out_frames_moved (out_frames_moved),
  .out_req_start    (out_req_start),
  .out_req_length   (out_req_length),
  .out_last         (out_last)
);

`default_nettype wire
